/* sv/pid_controller_step_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`define PID_CONTROLLER_STEP_TOP_ASSERT_SVH

// Concurrent check on clk, idle while arst_n is low.
`define PIDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	`PIDC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* sv/pidc_pkg.sv */
`timescale 1ns / 1ps

package pidc_pkg;

	localparam int DATA_W        = 32;
	localparam int DT_W          = 31;
	localparam int CTRL_W        = 2;
	localparam int CFG_IDX_W     = 3;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL       = 3'd7;

	localparam int CTRL_AUTO = 0;
	localparam int CTRL_REV  = 1;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// clamp to [lo, hi] when en, then saturate to 32 bits
	function automatic logic signed [DATA_W-1:0] clamp_sat(
		input logic signed [63:0]       v,
		input logic signed [DATA_W-1:0] lo,
		input logic signed [DATA_W-1:0] hi,
		input logic                     en
	);
		logic signed [63:0] r;
		r = v;
		if (en) begin
			if (v < 64'(lo)) begin
				r = 64'(lo);
			end else if (v > 64'(hi)) begin
				r = 64'(hi);
			end
		end
		if (r > 64'(S32_MAX)) begin
			r = 64'(S32_MAX);
		end else if (r < 64'(S32_MIN)) begin
			r = 64'(S32_MIN);
		end
		return r[DATA_W-1:0];
	endfunction

endpackage

/* sv/pidc_mul.sv */
`timescale 1ns / 1ps

module pidc_mul import pidc_pkg::*; (
	input  logic                       clk,
	input  logic signed [DATA_W-1:0]   a,
	input  logic signed [DATA_W-1:0]   b,
	output logic signed [2*DATA_W-1:0] prod
);

	logic signed [2*DATA_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* sv/pidc_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, unsigned operands.
module pidc_div import pidc_pkg::*; #(
	parameter int NUM_W = DATA_W + FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DT_W-1:0]  den,
	output logic [NUM_W-1:0] quot,
	output div_stat_t        stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DT_W-1:0]  den_q;
	logic [DT_W-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DT_W:0]    shifted;
	logic [DT_W:0]    sub;
	logic             ge;
	logic [DT_W-1:0]  rem_n;

	always_comb begin
		shifted = {rem_q, num_q[NUM_W-1]};
		ge      = shifted >= {1'b0, den_q};
		sub     = shifted - {1'b0, den_q};
		rem_n   = ge ? sub[DT_W-1:0] : shifted[DT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign quot      = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* sv/pid_controller_step_top.sv */
// Compute item: from acceptance it steps through ERR, MUL_I, ACC_I, TERM_P, TERM_I, WAIT_D
// (for the bit-serial derivative divider), MUL_D, TERM_D, CLAMP and DONE; the single 32x32
// multiplier is reused for the integral step and the P and I terms while the divide runs,
// and for the D term after it. Clear item and manual-mode item go from idle straight to DONE.
// One item in flight; next accepted on return to idle; a stalled output holds the block in DONE.
// Async reset (arst_n low) loads register defaults and zeroes controller state.
`timescale 1ns / 1ps

module pid_controller_step_top import pidc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] measurement,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] drive
);

	localparam int NUM_W  = DATA_W + FRAC_BITS;
	localparam int PROD_W = 2 * DATA_W;
	localparam int TERM_W = PROD_W - FRAC_BITS;
	localparam int ACC_W  = TERM_W + 2;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_ERR    = 11'b000_0000_0010,
		ST_MUL_I  = 11'b000_0000_0100,
		ST_ACC_I  = 11'b000_0000_1000,
		ST_TERM_P = 11'b000_0001_0000,
		ST_TERM_I = 11'b000_0010_0000,
		ST_WAIT_D = 11'b000_0100_0000,
		ST_MUL_D  = 11'b000_1000_0000,
		ST_TERM_D = 11'b001_0000_0000,
		ST_CLAMP  = 11'b010_0000_0000,
		ST_DONE   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [DT_W-1:0]          sample_period_q;
	logic signed [DATA_W-1:0] target_q, limit_low_q, limit_high_q;
	logic [CTRL_W-1:0]        control_q;

	// controller state
	logic signed [DATA_W-1:0] integral_q, last_error_q, held_q;

	// datapath
	logic signed [DATA_W-1:0] meas_q, err_q, deriv_q, res_q, drive_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     diff_neg_q;
	logic                     out_valid_q;

	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sel;
	logic signed [PROD_W-1:0] prod_shr;
	logic signed [TERM_W-1:0] term;
	logic                     term_neg;

	logic [DT_W-1:0]          dt_eff;
	logic signed [DATA_W:0]   err_wide;
	logic signed [DATA_W-1:0] err_c;
	logic signed [DATA_W:0]   diff;
	logic [DATA_W:0]          diff_mag;
	logic                     div_start;
	logic [NUM_W-1:0]         div_num;
	logic [NUM_W-1:0]         quot;
	div_stat_t                div_stat;
	logic                     quot_big;
	logic signed [DATA_W-1:0] deriv_c;
	logic signed [PROD_W-1:0] int_sum;
	logic                     limits_differ;
	logic                     out_free;

	logic signed [DATA_W-1:0] lo_new, hi_new;
	logic                     accept;

	assign accept        = in_valid && !in_stall;
	assign in_stall      = state_q != ST_IDLE;
	assign out_free      = !out_valid_q || !out_stall;
	assign limits_differ = limit_low_q != limit_high_q;
	assign dt_eff        = (sample_period_q == '0) ? DT_W'(1) : sample_period_q;

	always_comb begin
		err_wide = 33'(target_q) - 33'(meas_q);
		err_c    = clamp_sat(64'(err_wide), S32_MIN, S32_MAX, 1'b0);
		diff     = 33'(err_q) - 33'(last_error_q);
		diff_mag = diff[DATA_W] ? -diff : diff;
		div_num  = {diff_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
	end

	assign div_start = state_q == ST_MUL_I;

	// quotient saturation; magnitude below 2^31 fits either sign
	always_comb begin
		quot_big = |quot[NUM_W-1:DATA_W-1];
		if (diff_neg_q) begin
			deriv_c = quot_big ? S32_MIN : -$signed(quot[DATA_W-1:0]);
		end else begin
			deriv_c = quot_big ? S32_MAX : $signed(quot[DATA_W-1:0]);
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_I: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, dt_eff});
			end
			ST_ACC_I: begin
				mul_a = err_q;
				mul_b = gain_p_q;
			end
			ST_TERM_P: begin
				mul_a = integral_q;
				mul_b = gain_i_q;
			end
			ST_MUL_D: begin
				mul_a = deriv_q;
				mul_b = gain_d_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// reverse mode negates the gain products; arithmetic shift is a floor
	always_comb begin
		term_neg = control_q[CTRL_REV] &&
			(state_q == ST_TERM_P || state_q == ST_TERM_I || state_q == ST_TERM_D);
		prod_sel = term_neg ? -prod : prod;
		prod_shr = prod_sel >>> FRAC_BITS;
		term     = prod_shr[TERM_W-1:0];
		int_sum  = PROD_W'(integral_q) + prod_shr;
	end

	always_comb begin
		lo_new = (cfg_we && cfg_index == REG_LIMIT_LOW)  ? $signed(cfg_data) : limit_low_q;
		hi_new = (cfg_we && cfg_index == REG_LIMIT_HIGH) ? $signed(cfg_data) : limit_high_q;
	end

	pidc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pidc_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dt_eff),
		.quot   (quot),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			out_valid_q     <= 1'b0;
			gain_p_q        <= '0;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			sample_period_q <= DT_W'(1) << FRAC_BITS;
			target_q        <= '0;
			limit_low_q     <= '0;
			limit_high_q    <= '0;
			control_q       <= '0;
			integral_q      <= '0;
			last_error_q    <= '0;
			held_q          <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_P:        gain_p_q        <= $signed(cfg_data);
					REG_GAIN_I:        gain_i_q        <= $signed(cfg_data);
					REG_GAIN_D:        gain_d_q        <= $signed(cfg_data);
					REG_SAMPLE_PERIOD: sample_period_q <= cfg_data[DT_W-1:0];
					REG_TARGET:        target_q        <= $signed(cfg_data);
					REG_LIMIT_LOW, REG_LIMIT_HIGH: begin
						limit_low_q  <= lo_new;
						limit_high_q <= hi_new;
						if (lo_new < hi_new) begin
							held_q <= clamp_sat(64'(held_q), lo_new, hi_new, 1'b1);
						end
					end
					REG_CONTROL: begin
						// manual to auto restarts the integrator
						if (!control_q[CTRL_AUTO] && cfg_data[CTRL_AUTO]) begin
							integral_q   <= '0;
							last_error_q <= '0;
						end
						control_q <= cfg_data[CTRL_W-1:0];
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op) begin
							integral_q   <= '0;
							last_error_q <= '0;
							held_q       <= '0;
							state_q      <= ST_DONE;
						end else if (!control_q[CTRL_AUTO]) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_ERR:    state_q <= ST_MUL_I;
				ST_MUL_I: begin
					last_error_q <= err_q;
					state_q      <= ST_ACC_I;
				end
				ST_ACC_I: begin
					integral_q <= clamp_sat(64'(int_sum), limit_low_q, limit_high_q,
						limits_differ);
					state_q    <= ST_TERM_P;
				end
				ST_TERM_P: state_q <= ST_TERM_I;
				ST_TERM_I: state_q <= ST_WAIT_D;
				ST_WAIT_D: begin
					if (div_stat.done && !div_stat.busy) begin
						state_q <= ST_MUL_D;
					end
				end
				ST_MUL_D:  state_q <= ST_TERM_D;
				ST_TERM_D: state_q <= ST_CLAMP;
				ST_CLAMP: begin
					held_q  <= res_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				meas_q <= measurement;
				res_q  <= op ? '0 : held_q;
			end
			ST_ERR:    err_q      <= err_c;
			ST_MUL_I:  diff_neg_q <= diff[DATA_W];
			ST_TERM_P: acc_q      <= ACC_W'(term);
			ST_TERM_I: acc_q      <= acc_q + ACC_W'(term);
			ST_WAIT_D: deriv_q    <= deriv_c;
			ST_TERM_D: begin
				acc_q <= acc_q + ACC_W'(term);
			end
			ST_CLAMP: begin
			end
			default: begin
			end
		endcase
		if (state_q == ST_TERM_D) begin
			res_q <= clamp_sat(64'(acc_q + ACC_W'(term)), limit_low_q, limit_high_q,
				limits_differ);
		end
		if (state_q == ST_DONE && out_free) begin
			drive_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

/* sv/pidc_checker.sv */
`timescale 1ns / 1ps
`include "pid_controller_step_top_assert.svh"

module pidc_checker import pidc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] drive
);

	// a held result keeps its value
	`PIDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive), "result changed while stalled")

	// one transaction at a time: input closes right after acceptance
	`PIDC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

	// input reopens only once the result is in the output register
	`PIDC_ASSERT(a_result_on_reopen, $fell(in_stall) |-> out_valid, "idle without result")

	// a new result shows only as the block goes idle
	`PIDC_ASSERT(a_result_when_idle, $rose(out_valid) |-> !in_stall, "result while busy")

endmodule

bind pid_controller_step_top pidc_checker u_pidc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive)
);

/* bench/pid_controller_step_top_tb.sv */
`timescale 1ns / 1ps

module pid_controller_step_top_tb;
	import pidc_pkg::*;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;
	localparam int   FRAC       = FRAC_BITS_DEF;
	localparam int   CYCLE_LIMIT = 300000;
	localparam logic signed [63:0] WORD_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] WORD_MIN = 64'shffff_ffff_8000_0000;

	typedef struct {
		logic               op;
		logic signed [31:0] meas;
	} step_item_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [DATA_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     op = OP_COMPUTE;
	logic signed [DATA_W-1:0] measurement = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] drive;

	pid_controller_step_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive       (drive)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// controller copy: registers and state
	logic signed [31:0] k_p, k_i, k_d, tgt, lim_lo, lim_hi;
	logic [30:0]        dt_reg;
	logic [1:0]         ctl;
	logic signed [63:0] integ, prev_err, held;

	step_item_t         pending_q[$];
	logic signed [31:0] expected_drive_q[$];
	step_item_t         cur_item;
	logic signed [31:0] exp_drive;
	int                 mismatch_cnt = 0;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 hold_left = 0;
	bit                 hold_go = 1'b0;
	int                 cyc = 0;

	function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	function automatic logic signed [63:0] clamp_lim(input logic signed [63:0] v);
		logic signed [63:0] lo, hi;
		lo = lim_lo;
		hi = lim_hi;
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		case (idx)
			REG_GAIN_P:        k_p = val;
			REG_GAIN_I:        k_i = val;
			REG_GAIN_D:        k_d = val;
			REG_SAMPLE_PERIOD: dt_reg = val[30:0];
			REG_TARGET:        tgt = val;
			REG_LIMIT_LOW, REG_LIMIT_HIGH: begin
				if (idx == REG_LIMIT_LOW) lim_lo = val;
				else lim_hi = val;
				if (lim_lo < lim_hi) held = clamp_lim(held);
			end
			REG_CONTROL: begin
				// manual -> auto restarts the integrator
				if (!ctl[CTRL_AUTO] && val[CTRL_AUTO]) begin
					integ = 0;
					prev_err = 0;
				end
				ctl = val[1:0];
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [31:0] predict_drive(input logic clr,
			input logic signed [31:0] meas);
		logic signed [63:0] kp, ki, kd, dt, t64, m64, err, deriv, sum;
		logic               lims_on;
		if (clr == OP_CLEAR) begin
			integ = 0;
			prev_err = 0;
			held = 0;
			return '0;
		end
		if (!ctl[CTRL_AUTO]) return held[31:0];
		kp = k_p;
		ki = k_i;
		kd = k_d;
		if (ctl[CTRL_REV]) begin
			kp = -kp;
			ki = -ki;
			kd = -kd;
		end
		dt = {33'd0, dt_reg};
		if (dt == 0) dt = 1;
		lims_on = (lim_lo != lim_hi);
		t64 = tgt;
		m64 = meas;
		err = sat_word(t64 - m64);
		integ = integ + ((err * dt) >>> FRAC);
		if (lims_on) integ = clamp_lim(integ);
		integ = sat_word(integ);
		deriv = sat_word(((err - prev_err) * 64'sd65536) / dt);
		prev_err = err;
		sum = ((kp * err) >>> FRAC) + ((ki * integ) >>> FRAC) + ((kd * deriv) >>> FRAC);
		if (lims_on) sum = clamp_lim(sum);
		held = sat_word(sum);
		return held[31:0];
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_drive_q.push_back(predict_drive(cur_item.op, cur_item.meas));
			end
			if (!in_valid || !in_stall) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = pending_q.pop_front();
					in_valid <= 1'b1;
					op <= cur_item.op;
					measurement <= cur_item.meas;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_drive_q.size() == 0) begin
					$error("drive: no transaction expected, got %0d", drive);
					mismatch_cnt++;
				end else begin
					exp_drive = expected_drive_q.pop_front();
					if (drive !== exp_drive) begin
						$error("drive: expected %0d, got %0d", exp_drive, drive);
						mismatch_cnt++;
					end
				end
			end
			if (hold_left != 0) out_stall <= 1'b1;
			else out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left <= 400;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
	endtask

	task automatic load_regs(input logic [31:0] gp, gi, gd, dtv, tg, lo, hi, cv);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_SAMPLE_PERIOD, dtv);
		write_reg(REG_TARGET, tg);
		write_reg(REG_LIMIT_LOW, lo);
		write_reg(REG_LIMIT_HIGH, hi);
		write_reg(REG_CONTROL, cv);
	endtask

	task automatic send(input logic o, input logic [31:0] m);
		step_item_t it;
		it.op = o;
		it.meas = m;
		pending_q.push_back(it);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_q.size() != 0 || in_valid || expected_drive_q.size() != 0);
	endtask

	function automatic logic [31:0] small_word();
		logic [31:0] r;
		r = $urandom;
		return {{12{r[19]}}, r[19:0]};
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return $urandom;
			default: return small_word();
		endcase
	endfunction

	function automatic logic [31:0] pick_period();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return $urandom_range(32'h0000_0400, 32'h0004_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_meas();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return tgt + small_word();
		endcase
	endfunction

	task automatic random_setup();
		logic [31:0] a, b, lo, hi, cv;
		a = small_word();
		b = small_word();
		if ($signed(a) > $signed(b)) begin
			lo = b;
			hi = a;
		end else begin
			lo = a;
			hi = b;
		end
		case ($urandom_range(7))
			0: hi = lo;
			1: begin
				// inverted window
				a = lo;
				lo = hi;
				hi = a;
			end
			2: begin
				lo = 32'h8000_0000;
				hi = 32'h7fff_ffff;
			end
			default: ;
		endcase
		cv = {30'd0, 1'($urandom_range(1)), 1'($urandom_range(5) < 4)};
		load_regs(pick_gain(), pick_gain(), pick_gain(), pick_period(),
			($urandom_range(3) == 0) ? $urandom : small_word(), lo, hi, cv);
	endtask

	initial begin
		int idle_tab[4];
		int stall_tab[4];
		idle_tab  = '{0, 63, 0, 27};
		stall_tab = '{0, 0, 63, 27};

		k_p = '0;
		k_i = '0;
		k_d = '0;
		dt_reg = 31'(1) << FRAC;
		tgt = '0;
		lim_lo = '0;
		lim_hi = '0;
		ctl = '0;
		integ = 0;
		prev_err = 0;
		held = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults, manual mode
		send(OP_COMPUTE, 32'h0);
		send(OP_COMPUTE, 32'h7fff_ffff);
		send(OP_CLEAR, 32'h1234_5678);
		drain();

		// plain auto run, top bit of the period ignored
		load_regs(32'h0001_0000, 32'h0000_8000, 32'hffff_c000, 32'h8001_0000,
			32'h000a_0000, 32'hff9c_0000, 32'h0064_0000, 32'h1);
		send(OP_COMPUTE, 32'h0);
		send(OP_COMPUTE, 32'h0003_0000);
		send(OP_COMPUTE, 32'h7fff_ffff);
		send(OP_COMPUTE, 32'h8000_0000);
		send(OP_CLEAR, 32'h0);
		send(OP_COMPUTE, 32'hffff_ffff);
		drain();

		// reverse with most-negative gains, zero period, equal limits
		load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
			32'h8000_0000, 32'h0, 32'h0, 32'h3);
		send(OP_COMPUTE, 32'h7fff_ffff);
		send(OP_COMPUTE, 32'h8000_0000);
		send(OP_COMPUTE, 32'h0);
		drain();

		// max gains and period, inverted limits
		load_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h0064_0000, 32'hff9c_0000, 32'h1);
		send(OP_COMPUTE, 32'h8000_0000);
		send(OP_COMPUTE, 32'h7fff_ffff);
		send(OP_COMPUTE, 32'h0064_0000);
		send(OP_COMPUTE, 32'h0);
		drain();

		// manual: limit write clamps held output, then back to auto
		write_reg(REG_CONTROL, 32'h0);
		write_reg(REG_LIMIT_LOW, 32'hffff_0000);
		write_reg(REG_LIMIT_HIGH, 32'h0001_0000);
		send(OP_COMPUTE, 32'h0);
		send(OP_COMPUTE, 32'h1234_5678);
		drain();
		write_reg(REG_CONTROL, 32'h1);
		send(OP_COMPUTE, 32'h0002_0000);
		send(OP_COMPUTE, 32'hfffe_0000);
		send(OP_CLEAR, 32'hffff_ffff);
		send(OP_COMPUTE, 32'h0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			for (int sub = 0; sub < 4; sub++) begin
				random_setup();
				if (ph == 0 && sub == 1) begin
					@(negedge clk);
					hold_go = 1'b1;
				end
				for (int n = 0; n < 28; n++) begin
					send(($urandom_range(15) == 0) ? OP_CLEAR : OP_COMPUTE, pick_meas());
				end
				drain();
			end
		end

		repeat (60) @(posedge clk);
		if (mismatch_cnt == 0 && expected_drive_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/pidc_pkg.sv
sv/pidc_mul.sv
sv/pidc_div.sv
sv/pid_controller_step_top.sv
sv/pidc_checker.sv
bench/pid_controller_step_top_tb.sv
